### sv/exp_integrate_fire_neuron_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the exponential integrate-and-fire neuron
// Shared property wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EXP_INTEGRATE_FIRE_NEURON_MACROS_SVH
`define EXP_INTEGRATE_FIRE_NEURON_MACROS_SVH

// Same-cycle implication
`define EIFN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("eifn: same-cycle check failed");

// Next-cycle implication
`define EIFN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("eifn: next-cycle check failed");

`endif

### sv/eifn_pkg.sv
// ----------------------------------------------------------------------------
// eifn_pkg
// Shared types and constants of the exponential integrate-and-fire neuron.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eifn_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FIRING_THRESHOLD = 3'd0,
    CFG_PEAK_LEVEL       = 3'd1,
    CFG_MEMBRANE_RES     = 3'd2,
    CFG_SHARPNESS        = 3'd3,
    CFG_REST_LEVEL       = 3'd4,
    CFG_RESET_LEVEL      = 3'd5,
    CFG_REFRACTORY_PER   = 3'd6,
    CFG_TIME_STEP        = 3'd7
  } cfg_idx_e;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_RATIO,
    OP_THR,
    OP_X,
    OP_Y,
    OP_G,
    OP_TERM,
    OP_E,
    OP_C,
    OP_D
  } op_e;

  typedef struct packed {
    logic load;
    logic start;
    logic finish;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic fire;
    logic refr;
    logic done;
    logic last_term;
  } status_t;

  // Register reset values
  localparam logic signed [31:0] FTH_RST   = 32'sd983040;
  localparam logic signed [31:0] PEAK_RST  = 32'sd2621440;
  localparam logic        [30:0] RRES_RST  = 31'd131072;
  localparam logic        [30:0] SHARP_RST = 31'd6554;
  localparam logic signed [31:0] REST_RST  = 32'sd131072;
  localparam logic signed [31:0] RLEV_RST  = -32'sd262144;
  localparam logic        [30:0] PER_RST   = 31'd196608;
  localparam logic        [30:0] DT_RST    = 31'd655;

  // Q32 constants for the exponential
  localparam logic [33:0] LN2_Q32   = 34'd2977044472;
  localparam logic [33:0] LOG2E_Q32 = 34'd6196328019;
  localparam int          Q32_SHIFT = 32;

  // Taylor series length
  localparam logic [3:0]  TERMS = 4'd12;

endpackage

`default_nettype wire

### sv/eifn_mdu.sv
// ----------------------------------------------------------------------------
// eifn_mdu
// Shared multiply-divide unit: |a*b|/|c| or |a*b|>>sh, signed, saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eifn_mdu #(
  parameter int DATA_WIDTH = 32
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    start_i,
  input  wire                                    shift_i,
  input  wire  [5:0]                             sh_i,
  input  wire  signed [((DATA_WIDTH > 34) ? DATA_WIDTH : 34)-1:0] a_i,
  input  wire  signed [((DATA_WIDTH > 34) ? DATA_WIDTH : 34)-1:0] b_i,
  input  wire  signed [((DATA_WIDTH > 34) ? DATA_WIDTH : 34)-1:0] c_i,
  output logic signed [((DATA_WIDTH > 34) ? DATA_WIDTH : 34)-1:0] res_o,
  output logic                                   done_o
);

  localparam int VW = (DATA_WIDTH > 34) ? DATA_WIDTH : 34;
  localparam int UW = (DATA_WIDTH > 36) ? DATA_WIDTH : 36;
  localparam int PW = 2 * UW;
  localparam int CW = $clog2(PW + 1);
  localparam logic [PW-1:0] MAXV_P = (PW'(1) << (DATA_WIDTH - 1)) - PW'(1);
  localparam logic [PW-1:0] MINM_P = PW'(1) << (DATA_WIDTH - 1);

  typedef enum logic [2:0] {M_IDLE, M_MUL, M_SHIFT, M_DIV, M_SAT} mstate_e;

  mstate_e         st_q;
  logic [UW-1:0]   ma_q, mb_q, md_q;
  logic            neg_q, shift_q;
  logic [5:0]      sh_q;
  logic [PW-1:0]   num_q;
  logic [UW:0]     rem_q;
  logic [CW-1:0]   cnt_q;
  logic [VW-1:0]   mag_a, mag_b, mag_c;
  logic [UW:0]     trial;
  logic            qbit;

  // Operand magnitudes
  always_comb begin
    mag_a = a_i[VW-1] ? (VW'(0) - VW'(a_i)) : VW'(a_i);
    mag_b = b_i[VW-1] ? (VW'(0) - VW'(b_i)) : VW'(b_i);
    mag_c = c_i[VW-1] ? (VW'(0) - VW'(c_i)) : VW'(c_i);
    if (mag_c == '0) begin
      mag_c = VW'(1);
    end
  end

  // One restoring division step
  always_comb begin
    trial = {rem_q[UW-1:0], num_q[PW-1]};
    qbit  = (trial >= {1'b0, md_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= M_IDLE;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      case (st_q)
        M_IDLE: begin
          if (start_i) begin
            ma_q    <= UW'(mag_a);
            mb_q    <= UW'(mag_b);
            md_q    <= UW'(mag_c);
            neg_q   <= (a_i[VW-1] ^ b_i[VW-1]) ^ (c_i[VW-1] & !shift_i);
            shift_q <= shift_i;
            sh_q    <= sh_i;
            st_q    <= M_MUL;
          end
        end
        M_MUL: begin
          num_q <= ma_q * mb_q;
          rem_q <= '0;
          cnt_q <= '0;
          st_q  <= shift_q ? M_SHIFT : M_DIV;
        end
        M_SHIFT: begin
          num_q <= num_q >> sh_q;
          st_q  <= M_SAT;
        end
        M_DIV: begin
          rem_q <= qbit ? (trial - {1'b0, md_q}) : trial;
          num_q <= {num_q[PW-2:0], qbit};
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(PW - 1)) begin
            st_q <= M_SAT;
          end
        end
        M_SAT: begin
          if (!neg_q) begin
            res_o <= (num_q > MAXV_P) ? VW'(MAXV_P) : VW'(num_q);
          end else begin
            res_o <= (num_q > MINM_P) ? (VW'(0) - VW'(MINM_P)) : (VW'(0) - VW'(num_q));
          end
          done_o <= 1'b1;
          st_q   <= M_IDLE;
        end
        default: st_q <= M_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/eifn_datapath.sv
// ----------------------------------------------------------------------------
// eifn_datapath
// Registers, neuron state, operand selection and write-back around the MDU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eifn_datapath #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  [2:0]           cfg_index_i,
  input  wire  [31:0]          cfg_data_i,
  input  wire  [31:0]          in_data_i,
  input  eifn_pkg::cmd_t       cmd_i,
  output eifn_pkg::status_t    status_o,
  output logic [31:0]          out_data_o,
  output logic [1:0]           out_user_o
);

  localparam int VW = (DATA_WIDTH > 34) ? DATA_WIDTH : 34;
  localparam logic signed [VW-1:0] MAXV = (VW'(1) << (DATA_WIDTH - 1)) - VW'(1);
  localparam logic signed [VW-1:0] MINV = -MAXV - VW'(1);
  localparam logic signed [VW-1:0] ONE  = VW'(1) << FRACTION_BITS;
  localparam logic signed [VW-1:0] RESTART = VW'(((64'd1 << FRACTION_BITS) + 64'd500) / 64'd1000);

  // Saturate to the data range
  function automatic logic signed [VW-1:0] clampdw(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] r;
    r = v;
    if (v > MAXV) r = MAXV;
    if (v < MINV) r = MINV;
    return r;
  endfunction

  // Saturating add
  function automatic logic signed [VW-1:0] sadd(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic signed [VW:0] s;
    logic signed [VW-1:0] r;
    s = (VW+1)'(a) + (VW+1)'(b);
    if (s > (VW+1)'(MAXV)) r = MAXV;
    else if (s < (VW+1)'(MINV)) r = MINV;
    else r = VW'(s);
    return r;
  endfunction

  logic signed [31:0] fth_q, peak_q, rest_q, rlev_q;
  logic        [30:0] rres_q, sharp_q, per_q, dt_q;
  logic signed [VW-1:0] u_q, timer_q;
  logic signed [VW-1:0] ratio_q, thr_q, x_q, y_q, g_q, term_q, sum_q, acc_q;
  logic signed [31:0] cur_q;
  logic fire_q, refr_q;
  logic [3:0] i_q;
  eifn_pkg::op_e wb_op_q;

  logic signed [VW-1:0] fth_w, peak_w, rest_w, rlev_w, rres_w, s_w, per_w, dt_w;
  logic signed [VW-1:0] tdiv_w, k_w, nk_w, expv_w, lim_w, dv_w;
  logic signed [VW-1:0] op_a, op_b, op_c, res_w;
  logic op_shift;
  logic [5:0] op_sh;
  logic mdu_done;

  // Widen registers
  always_comb begin
    fth_w  = VW'(fth_q);
    peak_w = VW'(peak_q);
    rest_w = VW'(rest_q);
    rlev_w = VW'(rlev_q);
    rres_w = VW'(rres_q);
    per_w  = VW'(per_q);
    dt_w   = VW'(dt_q);
    s_w    = (sharp_q == '0) ? VW'(1) : VW'(sharp_q);
    tdiv_w = (timer_q == '0) ? VW'(1) : timer_q;
  end

  // Finish the exponential from the series sum and the integer part; limit the voltage step
  always_comb begin
    k_w  = y_q >>> FRACTION_BITS;
    nk_w = -k_w;
    if (!k_w[VW-1]) begin
      if (k_w >= VW'(DATA_WIDTH - 1)) expv_w = MAXV;
      else if (sum_q > (MAXV >>> k_w)) expv_w = MAXV;
      else expv_w = sum_q <<< k_w;
    end else begin
      expv_w = sum_q >> nk_w;
    end
    lim_w = sadd(peak_w, -u_q);
    dv_w  = (res_w > lim_w) ? lim_w : res_w;
  end

  // Operand selection
  always_comb begin
    op_a = ONE;
    op_b = ONE;
    op_c = ONE;
    op_shift = 1'b1;
    op_sh = 6'(FRACTION_BITS);
    case (cmd_i.op)
      eifn_pkg::OP_RATIO: begin
        op_a = per_w; op_b = ONE; op_c = tdiv_w; op_shift = 1'b0;
      end
      eifn_pkg::OP_THR: begin
        op_a = ratio_q; op_b = fth_w;
      end
      eifn_pkg::OP_X: begin
        op_a = sadd(u_q, -thr_q); op_b = ONE; op_c = s_w; op_shift = 1'b0;
      end
      eifn_pkg::OP_Y: begin
        op_a = x_q; op_b = VW'(eifn_pkg::LOG2E_Q32); op_sh = 6'(eifn_pkg::Q32_SHIFT);
      end
      eifn_pkg::OP_G: begin
        op_a = y_q & (ONE - VW'(1)); op_b = VW'(eifn_pkg::LN2_Q32);
        op_sh = 6'(eifn_pkg::Q32_SHIFT);
      end
      eifn_pkg::OP_TERM: begin
        op_a = term_q; op_b = g_q; op_c = VW'(i_q) <<< FRACTION_BITS; op_shift = 1'b0;
      end
      eifn_pkg::OP_E: begin
        op_a = s_w; op_b = expv_w;
      end
      eifn_pkg::OP_C: begin
        op_a = rres_w; op_b = VW'(cur_q);
      end
      eifn_pkg::OP_D: begin
        op_a = acc_q; op_b = dt_w;
      end
      default: op_shift = 1'b1;
    endcase
  end

  eifn_mdu #(.DATA_WIDTH(DATA_WIDTH)) u_mdu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .shift_i (op_shift),
    .sh_i    (op_sh),
    .a_i     (op_a),
    .b_i     (op_b),
    .c_i     (op_c),
    .res_o   (res_w),
    .done_o  (mdu_done)
  );

  // Status to the controller
  always_comb begin
    status_o.fire      = (u_q >= peak_w);
    status_o.refr      = (timer_q < per_w);
    status_o.done      = mdu_done;
    status_o.last_term = (i_q == eifn_pkg::TERMS);
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fth_q   <= eifn_pkg::FTH_RST;
      peak_q  <= eifn_pkg::PEAK_RST;
      rres_q  <= eifn_pkg::RRES_RST;
      sharp_q <= eifn_pkg::SHARP_RST;
      rest_q  <= eifn_pkg::REST_RST;
      rlev_q  <= eifn_pkg::RLEV_RST;
      per_q   <= eifn_pkg::PER_RST;
      dt_q    <= eifn_pkg::DT_RST;
    end else if (cfg_we_i) begin
      case (eifn_pkg::cfg_idx_e'(cfg_index_i))
        eifn_pkg::CFG_FIRING_THRESHOLD: fth_q   <= cfg_data_i;
        eifn_pkg::CFG_PEAK_LEVEL:       peak_q  <= cfg_data_i;
        eifn_pkg::CFG_MEMBRANE_RES:     rres_q  <= cfg_data_i[30:0];
        eifn_pkg::CFG_SHARPNESS:        sharp_q <= cfg_data_i[30:0];
        eifn_pkg::CFG_REST_LEVEL:       rest_q  <= cfg_data_i;
        eifn_pkg::CFG_RESET_LEVEL:      rlev_q  <= cfg_data_i;
        eifn_pkg::CFG_REFRACTORY_PER:   per_q   <= cfg_data_i[30:0];
        eifn_pkg::CFG_TIME_STEP:        dt_q    <= cfg_data_i[30:0];
        default: fth_q <= fth_q;
      endcase
    end
  end

  // Neuron state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q     <= clampdw(-(ONE >>> 1));
      timer_q <= clampdw(VW'(eifn_pkg::PER_RST));
      fire_q  <= 1'b0;
      refr_q  <= 1'b0;
      i_q     <= 4'd1;
      wb_op_q <= eifn_pkg::OP_NONE;
    end else begin
      if (cmd_i.load) begin
        cur_q  <= in_data_i;
        fire_q <= status_o.fire;
        refr_q <= !status_o.fire && status_o.refr;
        thr_q  <= fth_w;
        if (status_o.fire) begin
          u_q     <= clampdw(rlev_w);
          timer_q <= clampdw(RESTART);
        end
      end
      if (cmd_i.start) begin
        wb_op_q <= cmd_i.op;
      end
      // Write back the finished operation
      if (mdu_done) begin
        case (wb_op_q)
          eifn_pkg::OP_RATIO: ratio_q <= res_w;
          eifn_pkg::OP_THR: begin
            thr_q   <= res_w;
            timer_q <= sadd(timer_q, dt_w);
          end
          eifn_pkg::OP_X: x_q <= res_w;
          eifn_pkg::OP_Y: y_q <= res_w;
          eifn_pkg::OP_G: begin
            g_q    <= res_w;
            term_q <= ONE;
            sum_q  <= ONE;
            i_q    <= 4'd1;
          end
          eifn_pkg::OP_TERM: begin
            term_q <= res_w;
            sum_q  <= sadd(sum_q, res_w);
            i_q    <= i_q + 4'd1;
          end
          eifn_pkg::OP_E: acc_q <= sadd(sadd(rest_w, -u_q), res_w);
          eifn_pkg::OP_C: acc_q <= sadd(acc_q, res_w);
          eifn_pkg::OP_D: u_q <= sadd(u_q, dv_w);
          default: acc_q <= acc_q;
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_o <= u_q[31:0];
      out_user_o <= {refr_q, fire_q};
    end
  end

endmodule

`default_nettype wire

### sv/eifn_ctrl.sv
// ----------------------------------------------------------------------------
// eifn_ctrl
// Step sequencer: issues datapath operations and runs the stream handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eifn_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  input  eifn_pkg::status_t  status_i,
  output eifn_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RATIO, S_THR, S_X, S_Y, S_G, S_TERM, S_E, S_C, S_D, S_DONE
  } state_e;

  state_e state_q;
  logic   start_q;
  eifn_pkg::op_e op_q;
  logic   accept, emit;

  always_comb begin
    in_ready_o   = (state_q == S_IDLE);
    accept       = in_valid_i && in_ready_o;
    emit         = (state_q == S_DONE) && (!out_valid_o || out_ready_i);
    cmd_o.load   = accept;
    cmd_o.start  = start_q;
    cmd_o.finish = emit;
    cmd_o.op     = op_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      op_q        <= eifn_pkg::OP_NONE;
      out_valid_o <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (status_i.fire) begin
              state_q <= S_DONE;
            end else if (status_i.refr) begin
              state_q <= S_RATIO; start_q <= 1'b1; op_q <= eifn_pkg::OP_RATIO;
            end else begin
              state_q <= S_X; start_q <= 1'b1; op_q <= eifn_pkg::OP_X;
            end
          end
        end
        S_RATIO: if (status_i.done) begin
          state_q <= S_THR; start_q <= 1'b1; op_q <= eifn_pkg::OP_THR;
        end
        S_THR: if (status_i.done) begin
          state_q <= S_X; start_q <= 1'b1; op_q <= eifn_pkg::OP_X;
        end
        S_X: if (status_i.done) begin
          state_q <= S_Y; start_q <= 1'b1; op_q <= eifn_pkg::OP_Y;
        end
        S_Y: if (status_i.done) begin
          state_q <= S_G; start_q <= 1'b1; op_q <= eifn_pkg::OP_G;
        end
        S_G: if (status_i.done) begin
          state_q <= S_TERM; start_q <= 1'b1; op_q <= eifn_pkg::OP_TERM;
        end
        S_TERM: if (status_i.done) begin
          // Loop over the series, then scale by the slope
          start_q <= 1'b1;
          if (status_i.last_term) begin
            state_q <= S_E; op_q <= eifn_pkg::OP_E;
          end else begin
            op_q <= eifn_pkg::OP_TERM;
          end
        end
        S_E: if (status_i.done) begin
          state_q <= S_C; start_q <= 1'b1; op_q <= eifn_pkg::OP_C;
        end
        S_C: if (status_i.done) begin
          state_q <= S_D; start_q <= 1'b1; op_q <= eifn_pkg::OP_D;
        end
        S_D: if (status_i.done) begin
          state_q <= S_DONE; op_q <= eifn_pkg::OP_NONE;
        end
        S_DONE: begin
          if (emit) begin
            out_valid_o <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/exp_integrate_fire_neuron.sv
// ----------------------------------------------------------------------------
// exp_integrate_fire_neuron
// Exponential integrate-and-fire neuron, one time step per input transaction.
// ----------------------------------------------------------------------------
// Firing step: no multiply-divide operation, straight from accept to the result state.
// Other steps: shared multiply-divide unit with shift-scaled products and true divisions;
// 14 divisions with the refractory ratio (13 without).
// One step at a time; the result register frees the input while a result waits.
// Reset: asynchronous; registers take their defaults, voltage -0.5, timer = period.
`timescale 1ns / 1ps
`default_nettype none

`include "exp_integrate_fire_neuron_macros.svh"

module exp_integrate_fire_neuron #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [31:0] injected_current
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] voltage
  output logic [1:0]  m_axis_tuser    // [0] spiked, [1] refractory
);

  eifn_pkg::cmd_t    cmd;
  eifn_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  eifn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  eifn_datapath #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

  // A firing step never reports the raised threshold
  `EIFN_ASSERT_IMPL(a_spike_not_refr, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))
  // Busy after an accepted transaction
  `EIFN_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the exponential integrate-and-fire neuron. A clocked
// driver streams current samples from a queue; a clocked monitor compares each
// output transaction with a Q16.16 neuron model kept in the bench, across
// several register settings and idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import eifn_pkg::*;

  localparam longint MAXV     = 64'sd2147483647;
  localparam longint MINV     = -64'sd2147483648;
  localparam longint ONE      = 64'sd65536;
  localparam longint TWO32    = 64'sd4294967296;
  localparam longint LN2_K    = 64'sd2977044472;
  localparam longint LOG2E_K  = 64'sd6196328019;
  localparam longint RESTART  = (ONE + 500) / 1000;
  localparam int     MAX_CYC  = 30000000;
  localparam int     LONG_RX  = 3000;

  typedef struct packed {
    logic [31:0] voltage;
    logic        spiked;
    logic        refr;
  } step_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tready = 1'b0;
  wire         cfg_ready_o;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [31:0] m_axis_tdata;
  wire  [1:0]  m_axis_tuser;

  exp_integrate_fire_neuron u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Neuron model state and registers
  longint fth, peak, rres, sharp, rest, rlev, per, dt;
  longint vmem, timer;

  logic [31:0] current_q[$];
  step_res_t   expected_q[$];
  int          errors = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          rx_hold_req = 0;
  bit          rx_hold_used = 0;
  int          rx_hold_cnt = 0;
  int          cycles = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic longint clamp32(longint v);
    if (v > MAXV) return MAXV;
    if (v < MINV) return MINV;
    return v;
  endfunction

  function automatic longint sat_add(longint a, longint b);
    return clamp32(a + b);
  endfunction

  // a*b/c exact, truncated toward zero, saturated; zero divisor acts as one
  function automatic longint mul_div(longint a, longint b, longint c);
    bit           neg;
    logic [127:0] ma, mb, p, q;
    logic [127:0] d;
    neg = ((a < 0) != (b < 0)) != (c < 0);
    ma = 128'(a < 0 ? -a : a);
    mb = 128'(b < 0 ? -b : b);
    d  = 128'(c < 0 ? -c : c);
    if (d == 0) d = 1;
    p = ma * mb;
    q = p / d;
    if (!neg) return (q > 128'(MAXV)) ? MAXV : longint'(q[63:0]);
    if (q > 128'(MAXV + 1)) return MINV;
    return -longint'(q[63:0]);
  endfunction

  // Fixed-point exp: 2^k times a Taylor series of the fractional part
  function automatic longint fix_exp(longint x);
    longint y, k, f, g, term, sum;
    y = mul_div(x, LOG2E_K, TWO32);
    if (y >= 0) k = y >>> 16;
    else k = -((-y + ONE - 1) >>> 16);
    f = y - k * ONE;
    g = mul_div(f, LN2_K, TWO32);
    term = ONE;
    sum = ONE;
    for (int i = 1; i <= 12; i++) begin
      term = mul_div(term, g, ONE * i);
      sum = sat_add(sum, term);
    end
    if (k >= 0) begin
      if (k >= 31) return MAXV;
      if (sum > (MAXV >>> k)) return MAXV;
      return sum << k;
    end
    if (k <= -64) return 0;
    return sum >>> (-k);
  endfunction

  // Advance the neuron by one time step
  function automatic step_res_t neuron_step(logic [31:0] cur_bits);
    step_res_t r;
    longint    cur, u, thr, s, t, ratio, x, acc, dv, lim;
    cur = longint'($signed(cur_bits));
    u = vmem;
    r = '0;
    if (u >= peak) begin
      vmem = clamp32(rlev);
      timer = RESTART;
      r.spiked = 1'b1;
    end else begin
      thr = fth;
      s = (sharp == 0) ? 1 : sharp;
      if (timer < per) begin
        t = (timer == 0) ? 1 : timer;
        ratio = mul_div(per, ONE, t);
        thr = mul_div(ratio, fth, ONE);
        timer = sat_add(timer, dt);
        r.refr = 1'b1;
      end
      x = mul_div(sat_add(u, -thr), ONE, s);
      acc = sat_add(rest, -u);
      acc = sat_add(acc, mul_div(s, fix_exp(x), ONE));
      acc = sat_add(acc, mul_div(rres, cur, ONE));
      dv = mul_div(acc, dt, ONE);
      lim = sat_add(peak, -u);
      if (dv > lim) dv = lim;
      vmem = sat_add(u, dv);
    end
    r.voltage = vmem[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Drive current samples; predict each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(neuron_step(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (current_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_axis_tdata  <= current_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (rx_hold_cnt > 0) rx_hold_cnt <= rx_hold_cnt - 1;
    else if (rx_hold_req && !rx_hold_used) begin
      rx_hold_cnt <= LONG_RX;
      rx_hold_used <= 1'b1;
    end
  end

  // Check results and randomize output backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    step_res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, 0);
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata !== want.voltage)
            report_mismatch("voltage", $signed(m_axis_tdata), $signed(want.voltage));
          if (m_axis_tuser[0] !== want.spiked)
            report_mismatch("spiked", m_axis_tuser[0], want.spiked);
          if (m_axis_tuser[1] !== want.refr)
            report_mismatch("refractory", m_axis_tuser[1], want.refr);
        end
      end
      m_axis_tready <= (rx_hold_cnt == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FIRING_THRESHOLD: fth   = longint'($signed(val));
      CFG_PEAK_LEVEL:       peak  = longint'($signed(val));
      CFG_MEMBRANE_RES:     rres  = longint'(val[30:0]);
      CFG_SHARPNESS:        sharp = longint'(val[30:0]);
      CFG_REST_LEVEL:       rest  = longint'($signed(val));
      CFG_RESET_LEVEL:      rlev  = longint'($signed(val));
      CFG_REFRACTORY_PER:   per   = longint'(val[30:0]);
      CFG_TIME_STEP:        dt    = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                           logic [31:0] v3, logic [31:0] v4, logic [31:0] v5,
                           logic [31:0] v6, logic [31:0] v7);
    write_reg(CFG_FIRING_THRESHOLD, v0);
    write_reg(CFG_PEAK_LEVEL, v1);
    write_reg(CFG_MEMBRANE_RES, v2);
    write_reg(CFG_SHARPNESS, v3);
    write_reg(CFG_REST_LEVEL, v4);
    write_reg(CFG_RESET_LEVEL, v5);
    write_reg(CFG_REFRACTORY_PER, v6);
    write_reg(CFG_TIME_STEP, v7);
  endtask

  // Hold the sender until every prediction has been matched
  task automatic drain();
    while (current_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_current();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(1310720)) - 655360);
      2: return 32'($urandom_range(3276800));
      default: return 32'($signed($urandom_range(65536)) - 32768);
    endcase
  endfunction

  task automatic random_items(int n);
    repeat (n) current_q.push_back(rand_current());
  endtask

  initial begin
    fth = FTH_RST; peak = PEAK_RST; rres = RRES_RST; sharp = SHARP_RST;
    rest = REST_RST; rlev = RLEV_RST; per = PER_RST; dt = DT_RST;
    vmem = -(ONE / 2);
    timer = PER_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: current extremes at reset defaults, then spikes and refractory steps
    foreach (current_q[i]) ;
    current_q.push_back(32'h0000_0000);
    current_q.push_back(32'h7FFF_FFFF);
    current_q.push_back(32'h8000_0000);
    current_q.push_back(32'hFFFF_FFFF);
    current_q.push_back(32'h0000_0001);
    repeat (4) current_q.push_back(32'h7FFF_FFFF);
    repeat (6) current_q.push_back(32'h0001_0000);
    drain();

    // Zero sharpness and zero refractory period
    write_reg(CFG_SHARPNESS, 32'd0);
    write_reg(CFG_REFRACTORY_PER, 32'd0);
    repeat (5) current_q.push_back(32'h7FFF_FFFF);
    current_q.push_back(32'h8000_0000);
    drain();

    // Random phases over several settings and idle patterns
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 6)
        0: write_all(FTH_RST, PEAK_RST, RRES_RST, SHARP_RST, REST_RST, RLEV_RST,
                     PER_RST, DT_RST);
        1: write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: write_all(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h1, 32'h8000_0000,
                     32'h8000_0000, 32'h0, 32'h1);
        3: write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom());
        4: write_all(32'd983040, 32'd1310720, 32'd655360, 32'd13107, 32'd0,
                     -32'sd327680, 32'd131072, 32'd6554);
        default: write_all(32'($signed($urandom_range(2621440)) - 1310720),
                           32'($urandom_range(3932160)), 32'($urandom_range(262144)),
                           32'($urandom_range(65536, 1)),
                           32'($signed($urandom_range(262144)) - 131072),
                           32'($signed($urandom_range(524288)) - 393216),
                           32'($urandom_range(262144)), 32'($urandom_range(13107, 1)));
      endcase
      tx_idle_pct  = (ph % 4 == 1) ? 68 : (ph % 4 == 3) ? 10 : 0;
      rx_stall_pct = (ph % 4 == 2) ? 68 : (ph % 4 == 3) ? 10 : 0;
      rx_hold_req  = (ph == 4);
      random_items(50);
      drain();
      random_items(50);
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/eifn_pkg.sv
sv/eifn_mdu.sv
sv/eifn_datapath.sv
sv/eifn_ctrl.sv
sv/exp_integrate_fire_neuron.sv
tb/sv/testbench.sv
